@@ sv/pph_pkg.sv @@
`default_nettype none
package pph_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       conn_start;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  version;
    logic [16:0] hdr_bytes;
    logic [1:0]  addr_family;
    logic [31:0] src_ipv4;
    logic [63:0] src_ipv6_high;
    logic [63:0] src_ipv6_low;
    logic [15:0] sport;
  } out_t;

  localparam logic [1:0] VER_NONE = 2'd0;
  localparam logic [1:0] VER_V1   = 2'd1;
  localparam logic [1:0] VER_V2   = 2'd2;

  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_IPV4 = 2'd1;
  localparam logic [1:0] FAM_IPV6 = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // signatures and keywords, padded with zeros to a power of two
  localparam logic [0:7][7:0] TAG_V1 = {8'h50, 8'h52, 8'h4F, 8'h58, 8'h59, 8'h20, 8'h00, 8'h00};
  localparam logic [0:15][7:0] TAG_V2 = {8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D, 8'h0A, 8'h51,
                                         8'h55, 8'h49, 8'h54, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [0:7][7:0] KW_UNK = {8'h55, 8'h4E, 8'h4B, 8'h4E, 8'h4F, 8'h57, 8'h4E, 8'h00};
  localparam logic [0:7][7:0] KW_T4  = {8'h54, 8'h43, 8'h50, 8'h34, 8'h20, 8'h00, 8'h00, 8'h00};
  localparam logic [0:7][7:0] KW_T6  = {8'h54, 8'h43, 8'h50, 8'h36, 8'h20, 8'h00, 8'h00, 8'h00};

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

endpackage
`default_nettype wire

@@ sv/pph_core.sv @@
`default_nettype none
module pph_core #(
  parameter int V1_MAX_BYTES = 108
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire pph_pkg::in_t  item,
  output logic               emit,
  output pph_pkg::out_t      res
);

  typedef enum logic [3:0] {
    P_SIG, P_KEY, P_A4, P_A6, P_A6_COLON, P_A6_QUAD, P_DEST,
    P_PORT_LEAD, P_PORT_SIGN, P_PORT_DIG, P_PORT_REST, P_TAIL,
    P_V2_HDR, P_V2_BODY, P_DONE
  } phase_t;

  typedef enum logic [1:0] {GO_ON, GO_OK, GO_BAD} rc_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [7:0]  oct;
    logic [2:0]  cnt;
    logic        seen;
  } q_t;

  typedef struct packed {
    logic ok;
    q_t   q;
  } qr_t;

  typedef struct packed {
    logic            ok;
    logic [7:0][15:0] g;
  } cl_t;

  typedef struct packed {
    phase_t           phase;
    logic [16:0]      cnt;
    logic             cr;
    q_t               q;
    logic [7:0][15:0] g;
    logic [3:0]       gi;
    logic [3:0]       gap;
    logic [15:0]      port;
    logic [3:0]       cmd;
    logic [3:0]       fam;
    logic [15:0]      alen;
    logic [63:0]      s0;
    logic [63:0]      s1;
    logic             sig1;
    logic             sig2;
    logic             quad_ok;
    logic             colon_last;
    logic             neg;
    logic [2:0]       kw;
    logic [2:0]       hexd;
    logic [15:0]      hex;
    logic [1:0]       v1fam;
  } st_t;

  localparam logic [3:0] GAP_NONE = 4'd15;
  localparam logic [16:0] V1_MAX = 17'(V1_MAX_BYTES);

  function automatic st_t clear_st();
    st_t s;
    s = '0;
    s.phase = P_SIG;
    s.gap = GAP_NONE;
    s.sig1 = 1'b1;
    s.sig2 = 1'b1;
    s.quad_ok = 1'b1;
    return s;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // one character of a strict dotted quad
  function automatic qr_t quad_char(input q_t q, input logic [7:0] c);
    qr_t r;
    logic [11:0] nv;
    r.ok = 1'b0;
    r.q = q;
    nv = ({4'd0, q.oct} << 3) + ({4'd0, q.oct} << 1) + {8'd0, c[3:0]};
    if (is_digit(c)) begin
      if (!(q.seen && q.oct == 8'd0) && nv <= 12'd255) begin
        r.q.oct = nv[7:0];
        if (!q.seen) begin
          r.q.cnt = q.cnt + 3'd1;
          r.q.seen = 1'b1;
          r.ok = (q.cnt != 3'd4);
        end else begin
          r.ok = 1'b1;
        end
      end
    end else if (c == pph_pkg::CH_DOT && q.seen && q.cnt != 3'd4) begin
      r.q.acc = {q.acc[23:0], q.oct};
      r.q.oct = 8'd0;
      r.q.seen = 1'b0;
      r.ok = 1'b1;
    end
    return r;
  endfunction

  // expand a "::" gap so that the address fills all eight groups
  function automatic cl_t v6_close(input logic [7:0][15:0] g, input logic [3:0] gi,
                                   input logic [3:0] gap);
    cl_t r;
    logic [4:0] pos;
    r.g = g;
    if (gap == GAP_NONE) begin
      r.ok = (gi == 4'd8);
    end else begin
      r.ok = (gi < 4'd8) && (gap <= gi);
      for (int j = 0; j < 8; j++) begin
        pos = 5'(j) + {1'b0, gi} - {1'b0, gap};
        if (4'(j) < gap) r.g[j] = g[j];
        else if (pos >= 5'd8) r.g[j] = g[3'(j) + gi[2:0]];
        else r.g[j] = 16'd0;
      end
    end
    return r;
  endfunction

  st_t  st_r, st_nxt;
  st_t  s;
  rc_t  rc;
  qr_t  qr;
  cl_t  cl;
  logic [7:0] c;
  logic [16:0] idx, cnt1, k, off, total;
  logic crlf, do6, hexv, okw;
  logic [3:0] hexn;
  logic [7:0][15:0] gtmp;
  logic [3:0] gitmp;
  logic [31:0] qacc;

  always_comb begin
    s = item.conn_start ? clear_st() : st_r;
    st_nxt = s;
    emit = 1'b0;
    res = '0;
    rc = GO_ON;
    c = item.data_byte;
    idx = s.cnt;
    cnt1 = s.cnt + 17'd1;
    k = s.cnt - 17'd6;
    off = s.cnt - 17'd16;
    total = 17'd16 + {1'b0, s.alen};
    crlf = (c == pph_pkg::CH_LF) && s.cr;
    do6 = 1'b0;
    qr = '0;
    cl = '0;
    okw = 1'b1;
    gtmp = s.g;
    gitmp = s.gi;
    qacc = {s.q.acc[23:0], s.q.oct};
    hexv = 1'b1;
    hexn = c[3:0];
    if (is_digit(c)) hexn = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) hexn = c[3:0] + 4'd9;
    else hexv = 1'b0;

    if (s.phase != P_DONE) begin
      st_nxt.cnt = cnt1;
      unique case (s.phase)
        P_SIG: begin
          st_nxt.sig1 = s.sig1 && (idx >= 17'd6 || c == pph_pkg::TAG_V1[idx[2:0]]);
          st_nxt.sig2 = s.sig2 && (idx >= 17'd12 || c == pph_pkg::TAG_V2[idx[3:0]]);
          if (idx == 17'd5 && st_nxt.sig1) begin
            st_nxt.phase = P_KEY;
            st_nxt.kw = 3'b111;
            st_nxt.cr = 1'b0;
          end else if (idx >= 17'd11) begin
            if (st_nxt.sig2) begin
              st_nxt.phase = P_V2_HDR;
            end else begin
              emit = 1'b1;
              res.status = pph_pkg::STATUS_BAD;
              res.version = pph_pkg::VER_NONE;
            end
          end
        end
        P_V2_HDR, P_V2_BODY: begin
          if (s.phase == P_V2_HDR) begin
            if (idx == 17'd12) begin
              if (c[7:4] != 4'd2 || c[3:0] > 4'd1) begin
                emit = 1'b1;
                res.status = pph_pkg::STATUS_BAD;
                res.version = pph_pkg::VER_V2;
              end
              st_nxt.cmd = c[3:0];
            end else if (idx == 17'd13) begin
              st_nxt.fam = c[7:4];
            end else if (idx == 17'd14) begin
              st_nxt.alen = {c, 8'd0};
            end else begin
              st_nxt.alen = {s.alen[15:8], c};
              if ({s.alen[15:8], c} != 16'd0) st_nxt.phase = P_V2_BODY;
              else emit = 1'b1;
            end
          end else begin
            if (off < 17'd8) st_nxt.s0 = {s.s0[55:0], c};
            else if (off < 17'd16) st_nxt.s1 = {s.s1[55:0], c};
            if ((s.fam == 4'd1 && (off == 17'd8 || off == 17'd9)) ||
                (s.fam == 4'd2 && (off == 17'd32 || off == 17'd33)))
              st_nxt.port = {s.port[7:0], c};
            emit = (cnt1 == total);
          end
          // final word of a good v2 header
          if (emit && !res.status) begin
            res.version = pph_pkg::VER_V2;
            res.hdr_bytes = 17'd16 + {1'b0, st_nxt.alen};
            if (st_nxt.cmd == 4'd1 && st_nxt.fam == 4'd1 && st_nxt.alen >= 16'd12) begin
              res.addr_family = pph_pkg::FAM_IPV4;
              res.src_ipv4 = st_nxt.s0[63:32];
              res.sport = st_nxt.port;
            end else if (st_nxt.cmd == 4'd1 && st_nxt.fam == 4'd2 &&
                         st_nxt.alen >= 16'd36) begin
              res.addr_family = pph_pkg::FAM_IPV6;
              res.src_ipv6_high = st_nxt.s0;
              res.src_ipv6_low = st_nxt.s1;
              res.sport = st_nxt.port;
            end
          end
        end
        default: begin
          st_nxt.cr = (c == pph_pkg::CH_CR);
          unique case (s.phase)
            P_KEY: begin
              st_nxt.kw[0] = s.kw[0] && k < 17'd7 && c == pph_pkg::KW_UNK[k[2:0]];
              st_nxt.kw[1] = s.kw[1] && k < 17'd5 && c == pph_pkg::KW_T4[k[2:0]];
              st_nxt.kw[2] = s.kw[2] && k < 17'd5 && c == pph_pkg::KW_T6[k[2:0]];
              if (st_nxt.kw == 3'd0) begin
                rc = GO_BAD;
              end else if (st_nxt.kw[0] && k == 17'd6) begin
                st_nxt.v1fam = pph_pkg::FAM_NONE;
                st_nxt.phase = P_TAIL;
              end else if (st_nxt.kw[1] && k == 17'd4) begin
                st_nxt.v1fam = pph_pkg::FAM_IPV4;
                st_nxt.phase = P_A4;
                st_nxt.q = '0;
                st_nxt.quad_ok = 1'b1;
              end else if (st_nxt.kw[2] && k == 17'd4) begin
                st_nxt.v1fam = pph_pkg::FAM_IPV6;
                st_nxt.phase = P_A6;
                st_nxt.q = '0;
                st_nxt.quad_ok = 1'b1;
                st_nxt.gi = 4'd0;
                st_nxt.gap = GAP_NONE;
                st_nxt.hex = 16'd0;
                st_nxt.hexd = 3'd0;
                st_nxt.colon_last = 1'b0;
              end
            end
            P_A4: begin
              if (c == pph_pkg::CH_SP) begin
                if (s.q.cnt == 3'd4 && s.q.seen) begin
                  st_nxt.q.acc = qacc;
                  st_nxt.phase = P_DEST;
                end else begin
                  rc = GO_BAD;
                end
              end else begin
                qr = quad_char(s.q, c);
                if (qr.ok) st_nxt.q = qr.q;
                else rc = GO_BAD;
              end
            end
            P_A6: begin
              if (idx == 17'd11 && c == pph_pkg::CH_COLON) st_nxt.phase = P_A6_COLON;
              else do6 = 1'b1;
            end
            P_A6_COLON: begin
              if (c != pph_pkg::CH_COLON) begin
                rc = GO_BAD;
              end else begin
                st_nxt.phase = P_A6;
                do6 = 1'b1;
              end
            end
            P_A6_QUAD: begin
              if (c == pph_pkg::CH_SP) begin
                gtmp[s.gi[2:0]] = qacc[31:16];
                gtmp[s.gi[2:0] + 3'd1] = qacc[15:0];
                gitmp = s.gi + 4'd2;
                cl = v6_close(gtmp, gitmp, s.gap);
                if (!(s.q.cnt == 3'd4 && s.q.seen) || s.gi > 4'd6 || !cl.ok) begin
                  rc = GO_BAD;
                end else begin
                  st_nxt.q.acc = qacc;
                  st_nxt.g = cl.g;
                  st_nxt.gi = 4'd8;
                  st_nxt.phase = P_DEST;
                end
              end else begin
                qr = quad_char(s.q, c);
                if (qr.ok) st_nxt.q = qr.q;
                else rc = GO_BAD;
              end
            end
            P_DEST: begin
              if (crlf || c == 8'd0) begin
                rc = GO_BAD;
              end else if (c == pph_pkg::CH_SP) begin
                st_nxt.phase = P_PORT_LEAD;
                st_nxt.port = 16'd0;
                st_nxt.neg = 1'b0;
              end
            end
            P_PORT_LEAD, P_PORT_SIGN, P_PORT_DIG, P_PORT_REST: begin
              if (crlf || c == 8'd0) begin
                rc = GO_BAD;
              end else if (c == pph_pkg::CH_SP) begin
                if (s.neg) st_nxt.port = 16'd0 - s.port;
                st_nxt.phase = P_TAIL;
              end else if (is_digit(c) && s.phase != P_PORT_REST) begin
                st_nxt.port = (s.port << 3) + (s.port << 1) + {12'd0, c[3:0]};
                st_nxt.phase = P_PORT_DIG;
              end else if (s.phase == P_PORT_LEAD && c >= 8'd9 && c <= 8'd13) begin
                st_nxt.phase = P_PORT_LEAD;
              end else if (s.phase == P_PORT_LEAD &&
                           (c == pph_pkg::CH_PLUS || c == pph_pkg::CH_MINUS)) begin
                st_nxt.neg = (c == pph_pkg::CH_MINUS);
                st_nxt.phase = P_PORT_SIGN;
              end else begin
                st_nxt.phase = P_PORT_REST;
              end
            end
            P_TAIL: begin
              if (crlf) rc = GO_OK;
            end
            default: rc = GO_BAD;
          endcase

          if (do6) begin
            if (c == pph_pkg::CH_SP) begin
              if (s.hexd != 3'd0) begin
                okw = (s.gi < 4'd8);
                gtmp[s.gi[2:0]] = s.hex;
                gitmp = s.gi + 4'd1;
              end
              cl = v6_close(gtmp, gitmp, s.gap);
              if (s.colon_last || !okw || !cl.ok) begin
                rc = GO_BAD;
              end else begin
                st_nxt.g = cl.g;
                st_nxt.gi = 4'd8;
                st_nxt.phase = P_DEST;
              end
            end else begin
              st_nxt.colon_last = 1'b0;
              if (hexv) begin
                if (s.hexd == 3'd4) begin
                  rc = GO_BAD;
                end else begin
                  st_nxt.hex = {s.hex[11:0], hexn};
                  st_nxt.hexd = s.hexd + 3'd1;
                  if (s.quad_ok) begin
                    qr = quad_char(s.q, c);
                    st_nxt.quad_ok = qr.ok;
                    if (qr.ok) st_nxt.q = qr.q;
                  end
                end
              end else if (c == pph_pkg::CH_COLON) begin
                if (s.hexd == 3'd0) begin
                  if (s.gap != GAP_NONE) rc = GO_BAD;
                  else st_nxt.gap = s.gi;
                end else if (s.gi >= 4'd8) begin
                  rc = GO_BAD;
                end else begin
                  st_nxt.g[s.gi[2:0]] = s.hex;
                  st_nxt.gi = s.gi + 4'd1;
                  st_nxt.hex = 16'd0;
                  st_nxt.hexd = 3'd0;
                  st_nxt.colon_last = 1'b1;
                end
                st_nxt.q = '0;
                st_nxt.quad_ok = 1'b1;
              end else if (c == pph_pkg::CH_DOT && s.quad_ok && s.gi <= 4'd6) begin
                qr = quad_char(s.q, c);
                if (qr.ok) begin
                  st_nxt.q = qr.q;
                  st_nxt.phase = P_A6_QUAD;
                end else begin
                  rc = GO_BAD;
                end
              end else begin
                rc = GO_BAD;
              end
            end
          end

          if (rc == GO_OK) begin
            emit = 1'b1;
            res.version = pph_pkg::VER_V1;
            res.hdr_bytes = cnt1;
            res.addr_family = s.v1fam;
            if (s.v1fam == pph_pkg::FAM_IPV4) begin
              res.src_ipv4 = s.q.acc;
              res.sport = s.port;
            end else if (s.v1fam == pph_pkg::FAM_IPV6) begin
              res.src_ipv6_high = {s.g[0], s.g[1], s.g[2], s.g[3]};
              res.src_ipv6_low = {s.g[4], s.g[5], s.g[6], s.g[7]};
              res.sport = s.port;
            end
          end else if (rc == GO_BAD || cnt1 >= V1_MAX) begin
            emit = 1'b1;
            res.status = pph_pkg::STATUS_BAD;
            res.version = pph_pkg::VER_V1;
          end
        end
      endcase
      if (emit) st_nxt.phase = P_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= clear_st();
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/proxy_protocol_header_parser.sv @@
// PROXY protocol header parser. Feed the connection's bytes one word per
// cycle, with conn_start set on the first byte of each connection; one
// result word comes out per connection, when a text v1 or binary v2
// header completes or is found bad, and later bytes are dropped until the
// next conn_start. Each byte is latched in an input register, parsed by a
// single pass of logic, and any result is latched in an output register, so
// a new byte is taken every cycle unless a result sits unclaimed at the
// output. The result word is latched in the output register when the byte
// that completes or breaks the header leaves the input register.
`default_nettype none
module proxy_protocol_header_parser #(
  parameter int V1_MAX_BYTES = 108
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire pph_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pph_pkg::out_t      out_data
);

  logic          in_valid_r;
  pph_pkg::in_t  in_item_r;
  logic          out_valid_r;
  pph_pkg::out_t out_item_r;
  logic          adv;
  logic          emit;
  pph_pkg::out_t res;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  pph_core #(.V1_MAX_BYTES(V1_MAX_BYTES)) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (adv),
    .item (in_item_r),
    .emit (emit),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (adv && emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (in_valid && in_ready) in_item_r <= in_data;
    if (adv && emit) out_item_r <= res;
  end

endmodule
`default_nettype wire

@@ sv/pph_checker.sv @@
`default_nettype none
module pph_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire pph_pkg::out_t out_data
);

  // a rejected header carries nothing but status and version
  a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == pph_pkg::STATUS_BAD |->
      out_data.hdr_bytes == 17'd0 && out_data.addr_family == pph_pkg::FAM_NONE)
    else $error("reject word carries header fields");

  // acceptance only ever follows a recognized signature
  a_ok_has_version: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == pph_pkg::STATUS_OK |->
      out_data.version == pph_pkg::VER_V1 || out_data.version == pph_pkg::VER_V2)
    else $error("accepted header without version");

  a_no_family_no_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.addr_family == pph_pkg::FAM_NONE |-> out_data.sport == 16'd0)
    else $error("port reported without address family");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

endmodule

bind proxy_protocol_header_parser pph_checker u_pph_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
